[src/crlp_pkg.sv]
// ----------------------------------------------------------------------------
// crlp_pkg: shared types and constants of the cell report line parser
// Character codes, status codes, widths and the command beat that passes
// from the byte parser to the table executor.
// ----------------------------------------------------------------------------
package crlp_pkg;

  // field widths
  localparam int LINE_POS_W = 7;
  localparam int CELL_W     = 4;
  localparam int MV_W       = 16;
  localparam int RD_ACC_W   = 17;
  localparam int IDX_ACC_W  = 5;
  localparam int DIGITS_W   = 3;

  // command queue depth
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = 2;
  localparam int CMDQ_CNT_W = 3;

  // opcodes
  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  // characters
  localparam logic [7:0] CH_UPPER_C = 8'h43;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_LOWER_L = 8'h6C;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // parse limits
  localparam logic [LINE_POS_W-1:0] PREFIX_LAST   = 7'd3;
  localparam logic [LINE_POS_W-1:0] SHORT_LINE    = 7'd5;
  localparam logic [IDX_ACC_W-1:0]  IDX_SAT       = 5'd16;
  localparam logic [RD_ACC_W-1:0]   RD_SAT        = 17'd65536;
  localparam logic [DIGITS_W-1:0]   RD_DIGITS_MAX = 3'd7;
  localparam logic [DIGITS_W-1:0]   MIN_DIGITS    = 3'd4;
  localparam logic [CELL_W-1:0]     COUNT_RESET   = 4'd12;

  // result status codes
  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_EMPTY_LINE  = 3'd1,
    ST_NOT_CELL    = 3'd2,
    ST_BAD_READING = 3'd3,
    ST_OUTLIER     = 3'd4,
    ST_READ_ANSWER = 3'd5
  } status_t;

  // command beat from parser to executor
  typedef struct packed {
    logic                is_read;
    status_t             status;  // line class, ST_ACCEPTED means candidate
    logic [CELL_W-1:0]   cell_id; // one-based line cell, or zero-based read entry
    logic [MV_W-1:0]     mv;
  } cmd_t;

endpackage

[src/crlp_front.sv]
// ----------------------------------------------------------------------------
// crlp_front: byte parser
// Walks each report line byte by byte and, at a line end or a read request,
// emits one classified command beat for the executor.
// ----------------------------------------------------------------------------
module crlp_front #(
  parameter int CELLS      = 15,
  parameter int LINE_LIMIT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          opcode,
  input  logic [7:0]                    stream_byte,
  input  logic [crlp_pkg::CELL_W-1:0]   read_cell,
  output logic                          cmd_valid,
  output crlp_pkg::cmd_t                cmd
);

  typedef enum logic [6:0] {
    PH_PREFIX      = 7'b0000001,
    PH_PRE_INDEX   = 7'b0000010,
    PH_INDEX       = 7'b0000100,
    PH_PRE_COLON   = 7'b0001000,
    PH_POST_COLON  = 7'b0010000,
    PH_READING     = 7'b0100000,
    PH_DONE        = 7'b1000000
  } phase_t;

  // line state
  logic [crlp_pkg::LINE_POS_W-1:0] pos;
  phase_t                          phase;
  logic [crlp_pkg::IDX_ACC_W-1:0]  idx_acc;
  logic                            idx_digits;
  logic [crlp_pkg::RD_ACC_W-1:0]   rd_acc;
  logic [crlp_pkg::DIGITS_W-1:0]   rd_digits;
  logic                            rejected;

  phase_t                          phase_next;
  logic [crlp_pkg::IDX_ACC_W-1:0]  idx_acc_next;
  logic                            idx_digits_next;
  logic [crlp_pkg::RD_ACC_W-1:0]   rd_acc_next;
  logic [crlp_pkg::DIGITS_W-1:0]   rd_digits_next;
  logic                            rejected_next;

  logic       is_digit;
  logic [3:0] digit;
  logic       is_space;
  logic [7:0] word_char;
  logic [7:0] idx_v;
  logic [19:0] rd_v;
  logic       consumed;

  assign is_digit = (stream_byte >= crlp_pkg::CH_ZERO) && (stream_byte <= crlp_pkg::CH_NINE);
  assign digit    = 4'(stream_byte - crlp_pkg::CH_ZERO);
  assign is_space = (stream_byte == crlp_pkg::CH_SPACE);

  // expected prefix character at this position
  always_comb begin
    case (pos[1:0])
      2'd0:    word_char = crlp_pkg::CH_UPPER_C;
      2'd1:    word_char = crlp_pkg::CH_LOWER_E;
      default: word_char = crlp_pkg::CH_LOWER_L;
    endcase
  end

  // decimal accumulate by shift-add, then saturate
  assign idx_v = ({3'b0, idx_acc} << 3) + ({3'b0, idx_acc} << 1) + {4'b0, digit};
  assign rd_v  = ({3'b0, rd_acc} << 3) + ({3'b0, rd_acc} << 1) + {16'b0, digit};

  // one parse step; phases fall through until one consumes the byte
  always_comb begin
    phase_next      = phase;
    idx_acc_next    = idx_acc;
    idx_digits_next = idx_digits;
    rd_acc_next     = rd_acc;
    rd_digits_next  = rd_digits;
    rejected_next   = rejected;
    consumed        = 1'b0;
    if (!rejected) begin
      if (phase_next == PH_PREFIX) begin
        consumed = 1'b1;
        if (pos > crlp_pkg::PREFIX_LAST || stream_byte != word_char) begin
          rejected_next = 1'b1;
        end else if (pos == crlp_pkg::PREFIX_LAST) begin
          phase_next = PH_PRE_INDEX;
        end
      end
      if (!consumed && phase_next == PH_PRE_INDEX) begin
        if (is_space) begin
          consumed = 1'b1;
        end else if (!is_digit) begin
          rejected_next = 1'b1;
          consumed      = 1'b1;
        end else begin
          phase_next = PH_INDEX;
        end
      end
      if (!consumed && phase_next == PH_INDEX) begin
        if (is_digit) begin
          idx_acc_next    = (idx_v > 8'(crlp_pkg::IDX_SAT)) ? crlp_pkg::IDX_SAT
                                                            : idx_v[crlp_pkg::IDX_ACC_W-1:0];
          idx_digits_next = 1'b1;
          consumed        = 1'b1;
        end else begin
          phase_next = PH_PRE_COLON;
        end
      end
      if (!consumed && phase_next == PH_PRE_COLON) begin
        if (is_space) begin
          consumed = 1'b1;
        end else if (stream_byte == crlp_pkg::CH_COLON) begin
          phase_next = PH_POST_COLON;
          consumed   = 1'b1;
        end else begin
          phase_next = PH_POST_COLON;
        end
      end
      if (!consumed && phase_next == PH_POST_COLON) begin
        if (is_space) begin
          consumed = 1'b1;
        end else begin
          phase_next = PH_READING;
        end
      end
      if (!consumed && phase_next == PH_READING) begin
        if (is_digit) begin
          rd_acc_next = (rd_v > 20'(crlp_pkg::RD_SAT)) ? crlp_pkg::RD_SAT
                                                       : rd_v[crlp_pkg::RD_ACC_W-1:0];
          if (rd_digits < crlp_pkg::RD_DIGITS_MAX) begin
            rd_digits_next = rd_digits + 3'd1;
          end
        end else begin
          phase_next = PH_DONE;
        end
      end
    end
  end

  // line end classification and command build
  logic idx_ok;
  logic bad;
  logic [crlp_pkg::MV_W-1:0] mv_sat;

  assign idx_ok = (idx_acc != '0) && (idx_acc <= crlp_pkg::IDX_ACC_W'(CELLS));
  assign mv_sat = rd_acc[crlp_pkg::MV_W] ? {crlp_pkg::MV_W{1'b1}} : rd_acc[crlp_pkg::MV_W-1:0];
  assign bad    = !idx_ok || (rd_digits < crlp_pkg::MIN_DIGITS) || (rd_acc == '0)
                  || rd_acc[crlp_pkg::MV_W];

  always_comb begin
    cmd.is_read = 1'b0;
    cmd.status  = crlp_pkg::ST_EMPTY_LINE;
    cmd.cell_id = '0;
    cmd.mv      = '0;
    if (opcode == crlp_pkg::OP_READ) begin
      cmd.is_read = 1'b1;
      cmd.status  = crlp_pkg::ST_READ_ANSWER;
      cmd.cell_id = read_cell;
    end else if (pos == '0) begin
      cmd.status = crlp_pkg::ST_EMPTY_LINE;
    end else if (pos <= crlp_pkg::SHORT_LINE || rejected || !idx_digits) begin
      cmd.status = crlp_pkg::ST_NOT_CELL;
    end else begin
      cmd.status  = bad ? crlp_pkg::ST_BAD_READING : crlp_pkg::ST_ACCEPTED;
      cmd.cell_id = idx_ok ? idx_acc[crlp_pkg::CELL_W-1:0] : '0;
      cmd.mv      = mv_sat;
    end
  end

  assign cmd_valid = accept && ((opcode == crlp_pkg::OP_READ) || (stream_byte == crlp_pkg::CH_LF));

  // line state update on each kept feed byte (not CR, within the line limit)
  always_ff @(posedge clk) begin
    if (rst || (accept && opcode == crlp_pkg::OP_FEED && stream_byte == crlp_pkg::CH_LF)) begin
      pos        <= '0;
      phase      <= PH_PREFIX;
      idx_acc    <= '0;
      idx_digits <= 1'b0;
      rd_acc     <= '0;
      rd_digits  <= '0;
      rejected   <= 1'b0;
    end else if (accept && opcode == crlp_pkg::OP_FEED && stream_byte != crlp_pkg::CH_CR
                 && pos < crlp_pkg::LINE_POS_W'(LINE_LIMIT)) begin
      pos        <= pos + 7'd1;
      phase      <= phase_next;
      idx_acc    <= idx_acc_next;
      idx_digits <= idx_digits_next;
      rd_acc     <= rd_acc_next;
      rd_digits  <= rd_digits_next;
      rejected   <= rejected_next;
    end
  end

endmodule

[src/crlp_cmdq.sv]
// ----------------------------------------------------------------------------
// crlp_cmdq: command queue
// Short FIFO of command beats between the parser and the executor.
// ----------------------------------------------------------------------------
module crlp_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  crlp_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output crlp_pkg::cmd_t rd_data,
  output logic           full,
  output logic           nonempty
);

  crlp_pkg::cmd_t                  slots [crlp_pkg::CMDQ_DEPTH];
  logic [crlp_pkg::CMDQ_PTR_W-1:0] wr_ptr;
  logic [crlp_pkg::CMDQ_PTR_W-1:0] rd_ptr;
  logic [crlp_pkg::CMDQ_CNT_W-1:0] count;

  assign full     = (count == crlp_pkg::CMDQ_CNT_W'(crlp_pkg::CMDQ_DEPTH));
  assign nonempty = (count != '0);
  assign rd_data  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 3'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 3'd1;
      end
    end
  end

endmodule

[src/crlp_back.sv]
// ----------------------------------------------------------------------------
// crlp_back: table executor
// Holds the cell table and cell count, settles each line (outlier check,
// table write) or read, and keeps the result in an output register.
// ----------------------------------------------------------------------------
module crlp_back #(
  parameter int CELLS = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  crlp_pkg::cmd_t                cmd,
  output logic                          cmd_take,
  output logic                          empty,
  input  logic                          pop,
  output logic [2:0]                    status,
  output logic [crlp_pkg::CELL_W-1:0]   cell_number,
  output logic [crlp_pkg::MV_W-1:0]     millivolts,
  output logic [crlp_pkg::MV_W-1:0]     previous_mv,
  output logic [crlp_pkg::CELL_W-1:0]   cells_seen
);

  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [crlp_pkg::MV_W-1:0]   cell_table [CELLS];
  logic [crlp_pkg::CELL_W-1:0] count;
  logic                        out_valid;

  // table lookup
  logic [crlp_pkg::CELL_W-1:0] addr_full;
  logic [ADDR_W-1:0]           addr;
  logic                        in_range;
  logic [crlp_pkg::MV_W-1:0]   entry;

  assign addr_full = cmd.is_read ? cmd.cell_id : cmd.cell_id - 4'd1;
  assign addr      = addr_full[ADDR_W-1:0];
  assign in_range  = cmd.is_read ? (cmd.cell_id < crlp_pkg::CELL_W'(CELLS))
                                 : (cmd.cell_id != '0);
  assign entry     = in_range ? cell_table[addr] : '0;

  // outlier: diff > prev/10 is the same as 10*diff > prev
  logic [crlp_pkg::MV_W-1:0] diff;
  logic [19:0]               diff10;
  logic                      outlier;

  assign diff    = (cmd.mv > entry) ? cmd.mv - entry : entry - cmd.mv;
  assign diff10  = ({4'b0, diff} << 3) + ({4'b0, diff} << 1);
  assign outlier = (entry != '0) && (diff10 > {4'b0, entry});

  // result of the head command
  crlp_pkg::status_t           res_status;
  logic [crlp_pkg::CELL_W-1:0] res_cell;
  logic [crlp_pkg::MV_W-1:0]   res_mv;
  logic [crlp_pkg::MV_W-1:0]   res_prev;
  logic                        table_wr;
  logic [crlp_pkg::CELL_W-1:0] count_next;

  always_comb begin
    res_status = cmd.status;
    res_cell   = cmd.cell_id;
    res_mv     = cmd.mv;
    res_prev   = entry;
    table_wr   = 1'b0;
    count_next = count;
    if (cmd.is_read) begin
      res_status = crlp_pkg::ST_READ_ANSWER;
      res_cell   = in_range ? cmd.cell_id + 4'd1 : '0;
      res_mv     = entry;
      res_prev   = '0;
    end else if (cmd.status == crlp_pkg::ST_ACCEPTED) begin
      if (outlier) begin
        res_status = crlp_pkg::ST_OUTLIER;
      end else begin
        table_wr = 1'b1;
        if (cmd.cell_id > count) begin
          count_next = cmd.cell_id;
        end
      end
    end
  end

  assign empty    = !out_valid;
  assign cmd_take = cmd_valid && (!out_valid || pop);

  // table and count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        cell_table[i] <= '0;
      end
      count <= crlp_pkg::COUNT_RESET;
    end else if (cmd_take) begin
      if (table_wr) begin
        cell_table[addr] <= cmd.mv;
      end
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      status      <= res_status;
      cell_number <= res_cell;
      millivolts  <= res_mv;
      previous_mv <= res_prev;
      cells_seen  <= count_next;
    end
  end

endmodule

[src/cell_report_line_parser_top.sv]
// ----------------------------------------------------------------------------
// cell_report_line_parser_top: cell voltage report line parser
// Parses "Cell<n>: <mv>" report lines from a byte stream into a cell table
// and answers table reads.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: push/full with opcode, stream_byte, read_cell. A beat is
//   taken when push is high and full is low; one beat per cycle is sustained.
//   Feed beats (opcode 0) carry report bytes; CR is dropped, LF closes a line
//   and yields one result. Read beats (opcode 1) yield one result each.
//   Other bytes yield nothing.
//   Result queue: empty/pop with status, cell_number, millivolts,
//   previous_mv, cells_seen. A result is taken when pop is high and empty low.
//   Path: the edge that takes an input beat writes it into the command
//   queue; the executor then moves its result into the output register that
//   drives the ports. Throughput is one beat per cycle while the receiver
//   pops, as the executor updates the table as it takes each command.
//   A four-deep command queue sits between parser and executor; when the
//   receiver stalls, results back up into it and full rises once it holds
//   four waiting commands.
//   Reset (rst, synchronous): table cleared to zero, cell count 12, line
//   parse state cleared, both queues empty.
// ----------------------------------------------------------------------------
module cell_report_line_parser_top #(
  parameter int CELLS      = 15,
  parameter int LINE_LIMIT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          opcode,
  input  logic [7:0]                    stream_byte,
  input  logic [crlp_pkg::CELL_W-1:0]   read_cell,
  output logic                          empty,
  input  logic                          pop,
  output logic [2:0]                    status,
  output logic [crlp_pkg::CELL_W-1:0]   cell_number,
  output logic [crlp_pkg::MV_W-1:0]     millivolts,
  output logic [crlp_pkg::MV_W-1:0]     previous_mv,
  output logic [crlp_pkg::CELL_W-1:0]   cells_seen
);

  logic           accept;
  logic           q_push;
  crlp_pkg::cmd_t q_in;
  crlp_pkg::cmd_t q_head;
  logic           q_nonempty;
  logic           q_pop;

  assign accept = push && !full;

  // front: byte parser
  crlp_front #(
    .CELLS      (CELLS),
    .LINE_LIMIT (LINE_LIMIT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (opcode),
    .stream_byte (stream_byte),
    .read_cell   (read_cell),
    .cmd_valid   (q_push),
    .cmd         (q_in)
  );

  // command queue
  crlp_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_in),
    .rd_en    (q_pop),
    .rd_data  (q_head),
    .full     (full),
    .nonempty (q_nonempty)
  );

  // back: table executor
  crlp_back #(
    .CELLS (CELLS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_nonempty),
    .cmd         (q_head),
    .cmd_take    (q_pop),
    .empty       (empty),
    .pop         (pop),
    .status      (status),
    .cell_number (cell_number),
    .millivolts  (millivolts),
    .previous_mv (previous_mv),
    .cells_seen  (cells_seen)
  );

`ifndef SYNTHESIS
  // the command queue is never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !full)
    else $error("command queue written while full");

  // ordinary feed bytes never produce a command
  a_no_stray_cmd: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == crlp_pkg::OP_FEED && stream_byte != crlp_pkg::CH_LF) |-> !q_push)
    else $error("command pushed for a plain stream byte");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  // the cell count only grows from its reset value
  a_count_floor: assert property (@(posedge clk) disable iff (rst)
    !empty |-> cells_seen >= crlp_pkg::COUNT_RESET)
    else $error("cells_seen below reset count");
`endif

endmodule

[dv/cell_report_line_parser_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_report_line_parser_top_test: self-checking bench for the line parser
// Feeds report bytes and table reads through the push/full queue. A beat
// level predictor of the parser tracks the table, the cell count and the
// line state, and each result popped from the empty/pop side is checked field
// by field against the oldest predicted report. Directed lines cover every
// status and corner case; random traffic is mostly well-formed lines with
// random content, mixed with corrupted lines, noise, long lines and reads.
// ----------------------------------------------------------------------------
module cell_report_line_parser_top_test;

  localparam int NUM_CELLS   = 15;
  localparam int LINE_MAX    = 64;
  localparam int OUTLIER_DIV = 10;
  localparam int RANDOM_BEATS = 340;
  localparam int CALM_TAIL   = 80;   // no idling once this few beats are left
  localparam int HOLD_AT     = 200;  // beats taken before the long receiver hold
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000; // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic                        op;
    logic [7:0]                  data;
    logic [crlp_pkg::CELL_W-1:0] entry;
  } beat_t;

  typedef struct packed {
    crlp_pkg::status_t           st;
    logic [crlp_pkg::CELL_W-1:0] cell_num;
    logic [crlp_pkg::MV_W-1:0]   mv;
    logic [crlp_pkg::MV_W-1:0]   prev;
    logic [crlp_pkg::CELL_W-1:0] seen;
  } report_t;

  typedef enum logic [2:0] {
    PH_WORD, PH_PRE_INDEX, PH_INDEX, PH_PRE_COLON, PH_POST_COLON, PH_READING, PH_DONE
  } phase_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        push = 1'b0;
  logic                        full;
  logic                        opcode = crlp_pkg::OP_FEED;
  logic [7:0]                  stream_byte = 8'h00;
  logic [crlp_pkg::CELL_W-1:0] read_cell = '0;
  logic                        empty;
  logic                        pop = 1'b0;
  logic [2:0]                  status;
  logic [crlp_pkg::CELL_W-1:0] cell_number;
  logic [crlp_pkg::MV_W-1:0]   millivolts;
  logic [crlp_pkg::MV_W-1:0]   previous_mv;
  logic [crlp_pkg::CELL_W-1:0] cells_seen;

  cell_report_line_parser_top dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .stream_byte (stream_byte),
    .read_cell   (read_cell),
    .empty       (empty),
    .pop         (pop),
    .status      (status),
    .cell_number (cell_number),
    .millivolts  (millivolts),
    .previous_mv (previous_mv),
    .cells_seen  (cells_seen)
  );

  always #5 clk = ~clk;

  // stimulus and scoreboard storage
  beat_t   stream_beats[$];
  report_t pending_reports[$];
  int      planned_mv[NUM_CELLS];  // generator's guess of the table, steers near values
  bit      mix_reads = 1'b0;
  int      beats_taken = 0;
  int      beats_offered = 0;
  int      mismatches = 0;
  int      idle_cycles = 0;

  // parser model state
  logic [crlp_pkg::MV_W-1:0]       cell_mv[NUM_CELLS];
  logic [crlp_pkg::CELL_W-1:0]     high_cell;
  logic [crlp_pkg::LINE_POS_W-1:0] kept_bytes;
  phase_t                          phase;
  logic [crlp_pkg::IDX_ACC_W-1:0]  idx_val;
  bit                              idx_seen;
  logic [crlp_pkg::RD_ACC_W-1:0]   rd_val;
  logic [crlp_pkg::DIGITS_W-1:0]   rd_cnt;
  bit                              rejected;

  function automatic bit is_digit(logic [7:0] c);
    return c >= crlp_pkg::CH_ZERO && c <= crlp_pkg::CH_NINE;
  endfunction

  task automatic clear_line();
    kept_bytes = '0;
    phase      = PH_WORD;
    idx_val    = '0;
    idx_seen   = 1'b0;
    rd_val     = '0;
    rd_cnt     = '0;
    rejected   = 1'b0;
  endtask

  // one kept byte through the line grammar; later phases fall through
  task automatic parse_char(input logic [7:0] c);
    logic [7:0] word_ch;
    int v;
    if (rejected) return;
    if (phase == PH_WORD) begin
      case (kept_bytes[1:0])
        2'd0:    word_ch = crlp_pkg::CH_UPPER_C;
        2'd1:    word_ch = crlp_pkg::CH_LOWER_E;
        default: word_ch = crlp_pkg::CH_LOWER_L;
      endcase
      if (kept_bytes > crlp_pkg::PREFIX_LAST || c != word_ch) rejected = 1'b1;
      else if (kept_bytes == crlp_pkg::PREFIX_LAST) phase = PH_PRE_INDEX;
      return;
    end
    if (phase == PH_PRE_INDEX) begin
      if (c == crlp_pkg::CH_SPACE) return;
      if (!is_digit(c)) begin
        rejected = 1'b1;
        return;
      end
      phase = PH_INDEX;
    end
    if (phase == PH_INDEX) begin
      if (is_digit(c)) begin
        v = int'(idx_val) * 10 + int'(c - crlp_pkg::CH_ZERO);
        if (v > int'(crlp_pkg::IDX_SAT)) v = int'(crlp_pkg::IDX_SAT);
        idx_val = crlp_pkg::IDX_ACC_W'(v);
        idx_seen = 1'b1;
        return;
      end
      phase = PH_PRE_COLON;
    end
    if (phase == PH_PRE_COLON) begin
      if (c == crlp_pkg::CH_SPACE) return;
      phase = PH_POST_COLON;
      if (c == crlp_pkg::CH_COLON) return;
    end
    if (phase == PH_POST_COLON) begin
      if (c == crlp_pkg::CH_SPACE) return;
      phase = PH_READING;
    end
    if (phase == PH_READING) begin
      if (is_digit(c)) begin
        v = int'(rd_val) * 10 + int'(c - crlp_pkg::CH_ZERO);
        if (v > int'(crlp_pkg::RD_SAT)) v = int'(crlp_pkg::RD_SAT);
        rd_val = crlp_pkg::RD_ACC_W'(v);
        if (rd_cnt < crlp_pkg::RD_DIGITS_MAX) rd_cnt = rd_cnt + 3'd1;
        return;
      end
      phase = PH_DONE;
    end
  endtask

  // classify the finished line and update the table on an accepted reading
  task automatic finish_line(output report_t r);
    int mv, prev, diff, cell_no;
    bit idx_ok;
    r = '0;
    r.st = crlp_pkg::ST_ACCEPTED;
    mv = 0;
    prev = 0;
    cell_no = 0;
    if (kept_bytes == 0) begin
      r.st = crlp_pkg::ST_EMPTY_LINE;
    end else if (kept_bytes <= crlp_pkg::SHORT_LINE || rejected || !idx_seen) begin
      r.st = crlp_pkg::ST_NOT_CELL;
    end else begin
      idx_ok = idx_val >= 1 && idx_val <= NUM_CELLS;
      mv = (rd_val > 65535) ? 65535 : int'(rd_val);
      if (idx_ok) begin
        cell_no = int'(idx_val);
        prev = int'(cell_mv[cell_no-1]);
      end
      if (!idx_ok || rd_cnt < crlp_pkg::MIN_DIGITS || rd_val == 0 || rd_val > 65535) begin
        r.st = crlp_pkg::ST_BAD_READING;
      end else begin
        diff = (mv > prev) ? mv - prev : prev - mv;
        if (prev > 0 && diff > prev / OUTLIER_DIV) begin
          r.st = crlp_pkg::ST_OUTLIER;
        end else begin
          cell_mv[cell_no-1] = crlp_pkg::MV_W'(mv);
          if (cell_no > int'(high_cell)) high_cell = crlp_pkg::CELL_W'(cell_no);
        end
      end
    end
    r.cell_num = crlp_pkg::CELL_W'(cell_no);
    r.mv       = crlp_pkg::MV_W'(mv);
    r.prev     = crlp_pkg::MV_W'(prev);
    r.seen     = high_cell;
    clear_line();
  endtask

  // expected report for one accepted beat, if it yields one
  task automatic predict_cell_report(input beat_t b);
    report_t r;
    if (b.op == crlp_pkg::OP_READ) begin
      r = '0;
      r.st = crlp_pkg::ST_READ_ANSWER;
      if (b.entry < NUM_CELLS) begin
        r.cell_num = b.entry + 4'd1;
        r.mv       = cell_mv[b.entry];
      end
      r.seen = high_cell;
      pending_reports.push_back(r);
    end else if (b.data == crlp_pkg::CH_LF) begin
      finish_line(r);
      pending_reports.push_back(r);
    end else if (b.data != crlp_pkg::CH_CR && kept_bytes < LINE_MAX) begin
      parse_char(b.data);
      kept_bytes = kept_bytes + 7'd1;
    end
  endtask

  // stimulus builders
  task automatic add_read(input int entry);
    beat_t b;
    b.op    = crlp_pkg::OP_READ;
    b.data  = 8'($urandom_range(0, 255));
    b.entry = crlp_pkg::CELL_W'(entry);
    stream_beats.push_back(b);
  endtask

  task automatic add_byte(input logic [7:0] c);
    beat_t b;
    if (mix_reads && $urandom_range(0, 49) == 0) add_read($urandom_range(0, 15));
    b.op    = crlp_pkg::OP_FEED;
    b.data  = c;
    b.entry = crlp_pkg::CELL_W'($urandom_range(0, 15));
    stream_beats.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_line(input string s, input bit with_cr);
    add_text(s);
    if (with_cr) add_byte(crlp_pkg::CH_CR);
    add_byte(crlp_pkg::CH_LF);
  endtask

  // mostly well-formed report lines, some corrupted, noise and overlong ones
  task automatic add_random_line();
    int kind, idx, mv, start, pos, near;
    string txt;
    kind  = $urandom_range(0, 99);
    start = stream_beats.size();
    if (kind < 80) begin
      idx = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 99) : $urandom_range(1, NUM_CELLS);
      near = (idx >= 1 && idx <= NUM_CELLS) ? planned_mv[idx-1] : 0;
      if (near != 0 && $urandom_range(0, 4) != 0) begin
        mv = near + $urandom_range(0, near / 10) - near / 20;
      end else begin
        case ($urandom_range(0, 9))
          0:       mv = $urandom_range(0, 999);
          1:       mv = $urandom_range(60000, 200000);
          default: mv = $urandom_range(2500, 4300);
        endcase
      end
      txt = "Cell";
      repeat ($urandom_range(0, 2)) txt = {txt, " "};
      txt = {txt, $sformatf("%0d", idx)};
      repeat ($urandom_range(0, 2)) txt = {txt, " "};
      if ($urandom_range(0, 5) != 0) txt = {txt, ":"};
      repeat ($urandom_range(0, 2)) txt = {txt, " "};
      if ($urandom_range(0, 9) == 0) txt = {txt, $sformatf("%06d", mv)};
      else txt = {txt, $sformatf("%0d", mv)};
      if ($urandom_range(0, 1) != 0) txt = {txt, $sformatf(".%0d", $urandom_range(0, 999))};
      if ($urandom_range(0, 3) == 0) txt = {txt, " mV"};
      add_line(txt, $urandom_range(0, 2) == 0);
      if (kind >= 70) begin
        // corrupt one byte of the line body
        pos = $urandom_range(start, stream_beats.size() - 2);
        stream_beats[pos].data = 8'($urandom_range(0, 255));
      end else if (idx >= 1 && idx <= NUM_CELLS && mv >= 1000 && mv <= 65535 &&
                   (near == 0 || (mv - near <= near / 10 && near - mv <= near / 10))) begin
        planned_mv[idx-1] = mv;
      end
    end else if (kind < 92) begin
      repeat ($urandom_range(0, 20)) add_byte(8'($urandom_range(0, 255)));
      add_byte(crlp_pkg::CH_LF);
    end else begin
      add_text("Cell 9: 3");
      repeat ($urandom_range(55, 90)) add_byte(8'($urandom_range(8'h20, 8'h7E)));
      add_byte(crlp_pkg::CH_LF);
    end
    if ($urandom_range(0, 6) == 0) add_read($urandom_range(0, 15));
  endtask

  // sender: one beat at a time from the stimulus queue, changes at falling edge
  int send_gap = 0;
  beat_t next_beat;
  always @(negedge clk) begin
    if (!rst && beats_taken == beats_offered) begin
      if (send_gap > 0) begin
        push <= 1'b0;
        send_gap--;
      end else if (stream_beats.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        push <= 1'b0;
        send_gap = $urandom_range(0, 2);
      end else if (stream_beats.size() != 0) begin
        next_beat = stream_beats.pop_front();
        push        <= 1'b1;
        opcode      <= next_beat.op;
        stream_byte <= next_beat.data;
        read_cell   <= next_beat.entry;
        beats_offered++;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: random pop bursts, plus one long hold so the block backs up
  int  take_gap = 0;
  int  hold_left = 0;
  bit  held_once = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (!held_once && beats_taken >= HOLD_AT) begin
        pop <= 1'b0;
        held_once = 1'b1;
        hold_left = HOLD_CYCLES - 1;
      end else if (take_gap > 0) begin
        pop <= 1'b0;
        take_gap--;
      end else if (stream_beats.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        take_gap = $urandom_range(0, 2);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [16:0] want,
                             input logic [16:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // monitor: check popped results, then predict from the accepted input beat
  report_t want;
  beat_t   taken_beat;
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d cell %0d mv %0d",
                   $time, status, cell_number, millivolts);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("status", want.st, status);
          check_field("cell_number", want.cell_num, cell_number);
          check_field("millivolts", want.mv, millivolts);
          check_field("previous_mv", want.prev, previous_mv);
          check_field("cells_seen", want.seen, cells_seen);
        end
      end
      if (push && !full) begin
        taken_beat.op    = opcode;
        taken_beat.data  = stream_byte;
        taken_beat.entry = read_cell;
        predict_cell_report(taken_beat);
        beats_taken++;
      end
    end
  end

  // watchdog on cycles with no beat moving while work is outstanding
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (!rst && (stream_beats.size() != 0 || push || pending_reports.size() != 0)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("cell_report_line_parser_top_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int directed_beats;
    for (int i = 0; i < NUM_CELLS; i++) begin
      cell_mv[i]    = '0;
      planned_mv[i] = 0;
    end
    high_cell = crlp_pkg::COUNT_RESET;
    clear_line();

    // directed: reads of an empty table, empty lines, every status
    add_read(0);
    add_read(15);
    add_byte(crlp_pkg::CH_LF);
    add_line("", 1'b1);
    add_line("Cel", 1'b0);
    add_line("Cell 1: 3700", 1'b0);
    add_line("Cell1:3710.5", 1'b1);
    add_line("Cell 1: 4200", 1'b0);
    add_line("Cell 0: 3700", 1'b0);
    add_line("Cell 99: 3700", 1'b0);
    add_line("Cell 15 3650", 1'b0);
    add_line("Cell 2: 370", 1'b0);
    add_line("Cell 3: 0000", 1'b0);
    add_line("Cell 4: 9999999", 1'b0);
    add_line("Cell 5: 65535", 1'b0);
    add_line("Cellx 1: 3700", 1'b0);
    add_line("Cell :3700", 1'b0);
    add_line("Voltage 3700", 1'b0);
    add_line("Cell 6:", 1'b0);
    // reading straddles the line length limit, only two digits kept
    add_text("Cell 8:");
    repeat (55) add_byte(crlp_pkg::CH_SPACE);
    add_line("3800", 1'b0);
    add_read(0);
    add_read(4);
    add_read(14);
    planned_mv[0]  = 3710;
    planned_mv[14] = 3650;
    planned_mv[4]  = 65535;
    directed_beats = stream_beats.size();

    mix_reads = 1'b1;
    while (stream_beats.size() < directed_beats + RANDOM_BEATS) add_random_line();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stream_beats.size() != 0 || push || pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("cell_report_line_parser_top_test: PASS");
    end else begin
      $display("cell_report_line_parser_top_test: FAIL");
    end
    $finish;
  end

endmodule
